/* design/heat_stencil_sweep_macros.svh */
// assertion macros for the heat stencil sweep block
// expects a clock named clk and an active high reset named rst in the using scope
`ifndef HEAT_STENCIL_SWEEP_MACROS_SVH
`define HEAT_STENCIL_SWEEP_MACROS_SVH

// same-cycle implication, disabled during reset
`define HSS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define HSS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/hss_pkg.sv */
// shared constants for the heat stencil sweep block
// no dependencies
package hss_pkg;

  localparam int MAX_SIDE_DEF    = 1024;
  localparam int SAMPLE_BITS_DEF = 32;

  localparam int SIDE_W     = 11;
  localparam int COEFF_W    = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 16;
  localparam int MIN_SIDE   = 3;

  // input op codes
  localparam logic OP_SAMPLE = 1'b0;
  localparam logic OP_PAD    = 1'b1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_COEFF = 1'b1;

  localparam logic [SIDE_W-1:0]  SIDE_RESET  = 11'd3;
  localparam logic [COEFF_W-1:0] COEFF_RESET = 16'd0;

endpackage

/* design/heat_stencil_sweep.sv */
// heat stencil sweep: one explicit five-point Jacobi step over a raster grid
// depends on hss_pkg and heat_stencil_sweep_macros.svh
//
// channel   direction  handshake            payload
// in        to block   in_valid / in_ready  op, sample
// out       from block out_valid / out_ready node_value, frame_last
// cfg       to block   cfg_we (no wait)     cfg_index, cfg_data
//
// one item per cycle sustained while out_ready holds; an accepted item reaches the
// output register through five registers: the line store read (taken at the
// transfer edge), the window, the laplacian add, the coefficient multiply and
// the round/saturate stage
// results lag the input stream by side+1 items, so padding flushes a frame
// stages advance independently: a stall on out only holds back the items
// behind it once every stage ahead is full
// reset clears control and counters; the line store keeps whatever it holds
`include "heat_stencil_sweep_macros.svh"

module heat_stencil_sweep #(
  parameter int MAX_SIDE    = hss_pkg::MAX_SIDE_DEF,
  parameter int SAMPLE_BITS = hss_pkg::SAMPLE_BITS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // input channel
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               op,
  input  logic signed [SAMPLE_BITS-1:0]      sample,
  // output channel
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [SAMPLE_BITS-1:0]      node_value,
  output logic                               frame_last,
  // configuration writes
  input  logic                               cfg_we,
  input  logic [hss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [hss_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW   = SAMPLE_BITS;
  localparam int CW   = $clog2(MAX_SIDE);        // column / row index
  localparam int NW   = $clog2(MAX_SIDE + 1);    // holds the side itself
  localparam int LW   = SW + 3;                  // laplacian
  localparam int RW   = hss_pkg::COEFF_W + 1;    // coefficient as signed
  localparam int PW   = LW + RW;                 // product
  localparam int IW   = PW - hss_pkg::FRAC_BITS; // rounded increment
  localparam int VW   = IW + 1;                  // center plus increment
  localparam int FB   = hss_pkg::FRAC_BITS;

  localparam logic signed [PW-1:0] RND_HALF = PW'(1) <<< (FB - 1);
  localparam logic signed [VW-1:0] SAT_MAX  = VW'({1'b0, {(SW-1){1'b1}}});
  localparam logic signed [VW-1:0] SAT_MIN  = ~SAT_MAX;

  // configuration registers
  logic [hss_pkg::SIDE_W-1:0]  side_length;
  logic [hss_pkg::COEFF_W-1:0] diffusion_coeff;

  // effective side, clamped to the supported range
  logic [NW-1:0] n_eff;
  logic [NW-1:0] n_m1;
  logic [NW-1:0] n_m2;

  always_comb begin
    if (32'(side_length) > MAX_SIDE) begin
      n_eff = NW'(MAX_SIDE);
    end else if (32'(side_length) < hss_pkg::MIN_SIDE) begin
      n_eff = NW'(hss_pkg::MIN_SIDE);
    end else begin
      n_eff = NW'(side_length);
    end
    n_m1 = n_eff - NW'(1);
    n_m2 = n_eff - NW'(2);
  end

  // input side position: column and a row count that saturates at two
  logic [CW-1:0] in_col;
  logic [1:0]    in_rows;
  // output side position: next node to emit
  logic [CW-1:0] q_row;
  logic [CW-1:0] q_col;

  logic in_col_wrap, q_col_wrap;
  logic in_emit, in_interior, in_last;
  logic in_xfer;

  assign in_col_wrap = (NW'(in_col) == n_m1);
  assign q_col_wrap  = (NW'(q_col) == n_m1);

  // a result is due once side+1 items are in
  assign in_emit     = (in_rows == 2'd2) || ((in_rows == 2'd1) && (in_col != '0));
  assign in_interior = (q_row != '0) && (NW'(q_row) <= n_m2) &&
                       (q_col != '0) && (NW'(q_col) <= n_m2);
  assign in_last     = (NW'(q_row) == n_m1) && q_col_wrap;

  // stage valids and the ready chain
  logic s1_v, s2_v, s3_v, s4_v;
  logic out_free, s4_rdy, s3_rdy, s2_rdy, s1_rdy;
  // stage 2 flags
  logic s2_emit, s2_int, s2_last;

  assign out_free = !out_valid || out_ready;
  assign s4_rdy   = !s4_v || out_free;
  assign s3_rdy   = !s3_v || s4_rdy;
  assign s2_rdy   = !s2_v || s3_rdy;
  assign s1_rdy   = !s1_v || s2_rdy;
  assign in_ready = s1_rdy;
  assign in_xfer  = in_valid && in_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      side_length     <= hss_pkg::SIDE_RESET;
      diffusion_coeff <= hss_pkg::COEFF_RESET;
      in_col          <= '0;
      in_rows         <= '0;
      q_row           <= '0;
      q_col           <= '0;
      s1_v            <= 1'b0;
      s2_v            <= 1'b0;
      s3_v            <= 1'b0;
      s4_v            <= 1'b0;
      out_valid       <= 1'b0;
    end else begin
      if (in_xfer) begin
        if (in_emit && in_last) begin
          // frame done, both positions restart
          in_col  <= '0;
          in_rows <= '0;
          q_row   <= '0;
          q_col   <= '0;
        end else begin
          in_col <= in_col_wrap ? '0 : in_col + CW'(1);
          if (in_col_wrap && (in_rows != 2'd2)) begin
            in_rows <= in_rows + 2'd1;
          end
          if (in_emit) begin
            if (q_col_wrap) begin
              q_col <= '0;
              q_row <= q_row + CW'(1);
            end else begin
              q_col <= q_col + CW'(1);
            end
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          hss_pkg::CFG_SIDE: begin
            side_length <= cfg_data[hss_pkg::SIDE_W-1:0];
            in_col      <= '0;
            in_rows     <= '0;
            q_row       <= '0;
            q_col       <= '0;
          end
          hss_pkg::CFG_COEFF: begin
            diffusion_coeff <= cfg_data[hss_pkg::COEFF_W-1:0];
          end
          default: begin
          end
        endcase
      end
      if (s1_rdy)   s1_v      <= in_xfer;
      if (s2_rdy)   s2_v      <= s1_v;
      if (s3_rdy)   s3_v      <= s2_v && s2_emit;
      if (s4_rdy)   s4_v      <= s3_v;
      if (out_free) out_valid <= s4_v;
    end
  end

  // line store: one entry per column holding {row above, row of the center}
  // a column is read again only side items later (side >= 3), after its
  // write has landed, so no forwarding is needed; the one exception is the
  // first item of a new frame, which reads column zero while the last item
  // of the old frame writes it, and that read only feeds border nodes
  logic [2*SW-1:0] line_mem [MAX_SIDE];
  logic [2*SW-1:0] rd_data;
  logic signed [SW-1:0] rd_top, rd_mid;

  assign rd_top = rd_data[2*SW-1:SW];
  assign rd_mid = rd_data[SW-1:0];

  // stage 1 payload: the item waiting on its line store read
  logic signed [SW-1:0] s1_x;
  logic [CW-1:0]        s1_col;
  logic                 s1_emit, s1_int, s1_last;

  // window around the center: up, middle row, down (left column not needed
  // for the up and down rows)
  logic signed [SW-1:0] up_c, up_r, mid_l, mid_c, mid_r, dn_c, dn_r;

  // stage 3: laplacian
  logic signed [LW-1:0] s3_lap;
  logic signed [SW-1:0] s3_c;
  logic                 s3_int, s3_last;

  // stage 4: scaled laplacian
  logic signed [PW-1:0] s4_prod;
  logic signed [SW-1:0] s4_c;
  logic                 s4_int, s4_last;

  logic signed [LW-1:0] lap;
  logic signed [RW-1:0] coeff_s;

  assign lap = LW'(up_c) + LW'(dn_c) + LW'(mid_l) + LW'(mid_r) - (LW'(mid_c) <<< 2);
  assign coeff_s = $signed({1'b0, diffusion_coeff});

  // round to nearest, ties up, then add and saturate
  logic signed [PW-1:0] prod_rnd;
  logic signed [IW-1:0] inc;
  logic signed [VW-1:0] upd;
  logic signed [SW-1:0] upd_sat;

  always_comb begin
    prod_rnd = s4_prod + RND_HALF;
    inc      = $signed(prod_rnd[PW-1:FB]);
    upd      = VW'(s4_c) + VW'(inc);
    if (upd > SAT_MAX) begin
      upd_sat = SW'(SAT_MAX);
    end else if (upd < SAT_MIN) begin
      upd_sat = SW'(SAT_MIN);
    end else begin
      upd_sat = SW'(upd);
    end
  end

  // datapath registers and the line store
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      rd_data <= line_mem[in_col];
      s1_x    <= (op == hss_pkg::OP_PAD) ? '0 : sample;
      s1_col  <= in_col;
      s1_emit <= in_emit;
      s1_int  <= in_interior;
      s1_last <= in_last;
    end
    if (s1_v && s2_rdy) begin
      line_mem[s1_col] <= {rd_mid, s1_x};
      up_c    <= up_r;
      up_r    <= rd_top;
      mid_l   <= mid_c;
      mid_c   <= mid_r;
      mid_r   <= rd_mid;
      dn_c    <= dn_r;
      dn_r    <= s1_x;
      s2_emit <= s1_emit;
      s2_int  <= s1_int;
      s2_last <= s1_last;
    end
    if (s2_v && s3_rdy) begin
      s3_lap  <= lap;
      s3_c    <= mid_c;
      s3_int  <= s2_int;
      s3_last <= s2_last;
    end
    if (s3_v && s4_rdy) begin
      s4_prod <= s3_lap * coeff_s;
      s4_c    <= s3_c;
      s4_int  <= s3_int;
      s4_last <= s3_last;
    end
    if (s4_v && out_free) begin
      // border nodes pass the center through
      node_value <= s4_int ? upd_sat : s4_c;
      frame_last <= s4_last;
    end
  end

  // checks
  `HSS_ASSERT_IMP(a_col_range, 1'b1, NW'(in_col) < n_eff, "input column out of range")
  `HSS_ASSERT_IMP(a_no_mem_hazard, s1_v && s2_rdy && in_xfer && !(s1_emit && s1_last),
                  s1_col != in_col, "line store read and write hit the same column")
  `HSS_ASSERT_NXT(a_frame_restart, in_xfer && in_emit && in_last,
                  in_col == '0 && in_rows == 2'd0 && q_row == '0 && q_col == '0,
                  "positions did not restart after the last node")
  `HSS_ASSERT_IMP(a_corner_border, s4_v && s4_last, !s4_int,
                  "last node taken as interior")

endmodule

/* tb/sv/heat_stencil_sweep_test.sv */
// self-checking testbench for heat_stencil_sweep: raster grids in, updated nodes out
// depends on hss_pkg and the heat_stencil_sweep rtl; predicts every node in-line
`timescale 1ns / 100ps

module heat_stencil_sweep_test;

  localparam int SB            = hss_pkg::SAMPLE_BITS_DEF;
  localparam int GRID_MAX      = hss_pkg::MAX_SIDE_DEF;
  localparam int CDW           = hss_pkg::CFG_DATA_W;
  localparam int CYCLE_LIMIT   = 400000;
  // pipeline is five deep, leave some margin for items that make no result
  localparam int SETTLE_CYCLES = 12;
  localparam int RANDOM_ITEMS  = 1850;
  localparam int BIG_ITEMS     = 1028;
  localparam int LONG_HOLD     = 250;
  localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
  localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

  typedef struct {
    logic                 op;
    logic signed [SB-1:0] sample;
  } grid_item_t;

  typedef struct {
    logic signed [SB-1:0] value;
    logic                 is_last;
  } node_result_t;

  // block ports
  logic                           clk = 1'b0;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  logic                           op;
  logic signed [SB-1:0]           sample;
  logic                           out_valid;
  logic                           out_ready;
  logic signed [SB-1:0]           node_value;
  logic                           frame_last;
  logic                           cfg_we;
  logic [hss_pkg::CFG_IDX_W-1:0]  cfg_index;
  logic [CDW-1:0]                 cfg_data;

  // items waiting to be offered, and node values the block still owes us
  grid_item_t   items_out[$];
  node_result_t nodes_due[$];
  grid_item_t   next_item;
  node_result_t want;

  // predictor copy of the registers and the sweep state
  logic [hss_pkg::SIDE_W-1:0]  side_raw;
  logic [hss_pkg::COEFF_W-1:0] coeff_r;
  bit signed [SB-1:0]   row_mid [GRID_MAX];
  bit signed [SB-1:0]   row_top [GRID_MAX];
  bit signed [SB-1:0]   nbhd [3][3];
  int                   in_count;
  int                   out_node;

  // idling control and handshake bookkeeping
  int send_idle_pct;
  int recv_idle_pct;
  int send_gap_left;
  int ready_gap_left;
  int ready_hold_left;
  bit long_hold_done;
  bit in_xfer;

  // bookkeeping
  int cycle_count;
  int mismatches;
  int transfers_in;
  int results_seen;
  int frames_done;
  int reg_writes;
  int random_items;
  int widest_side;

  heat_stencil_sweep i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .sample     (sample),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .node_value (node_value),
    .frame_last (frame_last),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // side register is used clamped to the supported range
  function automatic int used_side();
    int s;
    s = int'(side_raw);
    if (s < hss_pkg::MIN_SIDE) s = hss_pkg::MIN_SIDE;
    if (s > GRID_MAX) s = GRID_MAX;
    return s;
  endfunction

  // u + r*(left+right+up+down-4u), r in Q0.16, rounded half up, saturated
  function automatic logic signed [SB-1:0] diffuse_node();
    longint ctr;
    longint lap;
    longint inc;
    longint v;
    ctr = nbhd[1][1];
    lap = longint'(nbhd[0][1]) + longint'(nbhd[2][1]) + longint'(nbhd[1][0])
          + longint'(nbhd[1][2]) - 4 * ctr;
    // the product stays well inside 64 bits: |lap| < 2^35, r < 2^16
    inc = (longint'(coeff_r) * lap + 64'sd32768) >>> 16;
    v = ctr + inc;
    if (v > longint'(S_MAX)) v = longint'(S_MAX);
    if (v < longint'(S_MIN)) v = longint'(S_MIN);
    return v[SB-1:0];
  endfunction

  // one accepted input transfer: shift the line stores and the window, and
  // queue the node that falls out once a row and one node have gone by
  task automatic step_heat_grid(input logic op_in, input logic signed [SB-1:0] smp);
    int                 n;
    int                 p;
    int                 col;
    int                 q;
    int                 row;
    int                 qc;
    bit signed [SB-1:0] x;
    bit signed [SB-1:0] top;
    bit signed [SB-1:0] mid;
    bit                 interior;
    node_result_t       res;
    n = used_side();
    p = in_count;
    col = p % n;
    // padding counts as a zero node inside the grid
    x = (op_in == hss_pkg::OP_PAD) ? '0 : smp;
    top = row_top[col];
    mid = row_mid[col];
    row_top[col] = mid;
    row_mid[col] = x;
    for (int k = 0; k < 3; k++) begin
      nbhd[k][0] = nbhd[k][1];
      nbhd[k][1] = nbhd[k][2];
    end
    nbhd[0][2] = top;
    nbhd[1][2] = mid;
    nbhd[2][2] = x;
    in_count = p + 1;
    if (p >= n + 1) begin
      q = out_node;
      row = q / n;
      qc = q % n;
      interior = row >= 1 && row + 2 <= n && qc >= 1 && qc + 2 <= n;
      // border nodes pass straight through
      res.value = interior ? diffuse_node() : nbhd[1][1];
      res.is_last = (q + 1 == n * n);
      nodes_due.push_back(res);
      if (res.is_last) begin
        in_count = 0;
        out_node = 0;
      end else begin
        out_node = q + 1;
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_item(input logic o, input logic signed [SB-1:0] v);
    grid_item_t it;
    it.op = o;
    it.sample = v;
    items_out.push_back(it);
  endfunction

  // mix of extremes, full-range noise, medium and small values so that the
  // update neither always saturates nor always stays tiny
  function automatic logic signed [SB-1:0] pick_sample();
    case ($urandom_range(7))
      0: begin
        case ($urandom_range(4))
          0: return S_MIN;
          1: return S_MAX;
          2: return '0;
          3: return '1;
          default: return 1;
        endcase
      end
      1, 2: return $urandom;
      3: return $signed($urandom) >>> 6;
      default: return $urandom_range(2097151) - 1048576;
    endcase
  endfunction

  function automatic logic [CDW-1:0] pick_coeff();
    case ($urandom_range(5))
      0: return '0;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return CDW'($urandom_range(255));
      default: return CDW'($urandom);
    endcase
  endfunction

  // mostly small grids; a few below the minimum and a few with junk above bit 10
  function automatic logic [CDW-1:0] pick_side_word();
    case ($urandom_range(19))
      0, 1: return CDW'($urandom_range(2));
      2: return 16'hF800 | CDW'($urandom_range(8, 3));
      3, 4: return CDW'($urandom_range(16, 9));
      default: return CDW'($urandom_range(8, 3));
    endcase
  endfunction

  // one frame: n*n nodes then n+1 flush items; noisy frames drop padding into
  // the grid, and the tail carries some samples that must act as padding
  task automatic queue_frame(input int n, input bit noisy, input int cut);
    int total;
    total = n * n + n + 1;
    if (cut > 0 && cut < total) total = cut;
    for (int i = 0; i < total; i++) begin
      if (i < n * n)
        push_item((noisy && $urandom_range(9) == 0) ? hss_pkg::OP_PAD : hss_pkg::OP_SAMPLE,
                  pick_sample());
      else
        push_item(($urandom_range(3) == 0) ? hss_pkg::OP_SAMPLE : hss_pkg::OP_PAD,
                  pick_sample());
    end
    random_items += total;
  endtask

  // register write; the block is idle so the predictor follows at once
  task automatic write_reg(input logic [hss_pkg::CFG_IDX_W-1:0] idx,
                           input logic [CDW-1:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    if (idx == hss_pkg::CFG_SIDE) begin
      side_raw = val[hss_pkg::SIDE_W-1:0];
      in_count = 0;
      out_node = 0;
      if (used_side() > widest_side) widest_side = used_side();
    end else if (idx == hss_pkg::CFG_COEFF) begin
      coeff_r = val[hss_pkg::COEFF_W-1:0];
    end
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // everything sent and answered, then let the pipeline empty out
  task automatic drain_block();
    while (items_out.size() != 0 || in_valid || nodes_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // driver: input channel, changes on the falling edge
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_xfer) begin
      // the current item is gone (or none was up): idle or offer the next one
      if (send_gap_left > 0) begin
        send_gap_left--;
        in_valid <= 1'b0;
      end else if (items_out.size() == 0) begin
        in_valid <= 1'b0;
      end else if ($urandom_range(99) < send_idle_pct) begin
        send_gap_left = $urandom_range(9);
        in_valid <= 1'b0;
      end else begin
        next_item = items_out.pop_front();
        in_valid <= 1'b1;
        op <= next_item.op;
        sample <= next_item.sample;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready: random bursts plus one long hold while input keeps coming,
  // which backs the pipeline up until in_ready drops
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!long_hold_done && results_seen >= 300 && items_out.size() > 40) begin
      long_hold_done = 1'b1;
      ready_hold_left = LONG_HOLD;
    end
    if (rst) begin
      out_ready <= 1'b0;
    end else if (ready_hold_left > 0) begin
      ready_hold_left--;
      out_ready <= 1'b0;
    end else if (ready_gap_left > 0) begin
      ready_gap_left--;
      out_ready <= 1'b0;
    end else if ($urandom_range(99) < recv_idle_pct) begin
      ready_gap_left = $urandom_range(9);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: both handshakes sampled on the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    in_xfer = 1'b0;
    if (!rst && in_valid && in_ready) begin
      in_xfer = 1'b1;
      transfers_in++;
      step_heat_grid(op, sample);
    end
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (nodes_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result with nothing pending: value %h last %b",
                   $realtime, node_value, frame_last);
      end else begin
        want = nodes_due.pop_front();
        if (node_value !== want.value || frame_last !== want.is_last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: result %0d: expected value %h last %b, got value %h last %b",
                     $realtime, results_seen, want.value, want.is_last,
                     node_value, frame_last);
        end else if (frame_last) begin
          frames_done++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus sequence
  // ---------------------------------------------------------------------------
  initial begin
    int  n;
    int  frames;
    int  cut;
    bit  big_done;
    bit  calm;
    rst = 1'b1;
    in_valid = 1'b0;
    op = hss_pkg::OP_SAMPLE;
    sample = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = hss_pkg::CFG_SIDE;
    cfg_data = '0;
    side_raw = hss_pkg::SIDE_RESET;
    coeff_r = hss_pkg::COEFF_RESET;
    in_count = 0;
    out_node = 0;
    widest_side = used_side();
    send_idle_pct = 20;
    recv_idle_pct = 20;
    big_done = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset settings (side 3, r = 0): field extremes pass through unchanged,
    // padding lands on the one interior node, samples sit in the flush tail
    push_item(hss_pkg::OP_SAMPLE, S_MIN);
    push_item(hss_pkg::OP_SAMPLE, S_MAX);
    push_item(hss_pkg::OP_SAMPLE, '0);
    push_item(hss_pkg::OP_SAMPLE, '1);
    push_item(hss_pkg::OP_PAD, 32'h5A5A5A5A);
    push_item(hss_pkg::OP_SAMPLE, 1);
    push_item(hss_pkg::OP_SAMPLE, 32'h55555555);
    push_item(hss_pkg::OP_SAMPLE, 32'hAAAAAAAA);
    push_item(hss_pkg::OP_SAMPLE, 32'h00010000);
    push_item(hss_pkg::OP_SAMPLE, 32'h12345678);
    push_item(hss_pkg::OP_PAD, S_MAX);
    push_item(hss_pkg::OP_SAMPLE, S_MIN);
    push_item(hss_pkg::OP_PAD, '0);
    drain_block();

    // full coefficient, side word with junk above the register width:
    // a minimum centre ringed by maximum neighbors must clip high
    write_reg(hss_pkg::CFG_COEFF, 16'hFFFF);
    write_reg(hss_pkg::CFG_SIDE, 16'hF803);
    for (int i = 0; i < 9; i++)
      push_item(hss_pkg::OP_SAMPLE, (i == 4) ? S_MIN : S_MAX);
    for (int i = 0; i < 4; i++)
      push_item(hss_pkg::OP_PAD, '0);
    drain_block();

    // random phases, each under a fresh setting; the last stretch runs flat out
    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if (!big_done && random_items >= 900) begin
        // largest grid: only the first three border nodes of the top row are reachable
        big_done = 1'b1;
        send_idle_pct = 10;
        recv_idle_pct = 10;
        write_reg(hss_pkg::CFG_COEFF, CDW'($urandom));
        write_reg(hss_pkg::CFG_SIDE, 16'hFFFF);
        for (int i = 0; i < BIG_ITEMS; i++)
          push_item(($urandom_range(15) == 0) ? hss_pkg::OP_PAD : hss_pkg::OP_SAMPLE,
                    pick_sample());
        random_items += BIG_ITEMS;
        drain_block();
      end
      calm = random_items >= RANDOM_ITEMS - 250;
      case ($urandom_range(3))
        0: send_idle_pct = 0;
        1: send_idle_pct = 5;
        2: send_idle_pct = 20;
        default: send_idle_pct = 40;
      endcase
      case ($urandom_range(3))
        0: recv_idle_pct = 0;
        1: recv_idle_pct = 5;
        2: recv_idle_pct = 20;
        default: recv_idle_pct = 40;
      endcase
      if (calm) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      write_reg(hss_pkg::CFG_COEFF, pick_coeff());
      write_reg(hss_pkg::CFG_SIDE, pick_side_word());
      n = used_side();
      frames = $urandom_range(3, 1);
      for (int f = 0; f < frames; f++) begin
        cut = 0;
        // now and then stop mid-frame; the next side write restarts it
        if (f == frames - 1 && $urandom_range(6) == 0)
          cut = $urandom_range(n * n + n, 1);
        queue_frame(n, $urandom_range(3) == 0, cut);
      end
      drain_block();
    end

    repeat (20) @(posedge clk);
    mismatches += nodes_due.size();
    $display("covered %0d input transfers, %0d results, %0d complete frames",
             transfers_in, results_seen, frames_done);
    $display("%0d register writes, grid sides 3 to %0d, %0d mismatches",
             reg_writes, widest_side, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

/* sim.f */
+incdir+design
design/hss_pkg.sv
design/heat_stencil_sweep.sv
tb/sv/heat_stencil_sweep_test.sv
